### sv/uart_pkg.sv
// ----------------------------------------------------------------------------
// uart_pkg
// shared constants and types for the oversampled 8n1 uart transceiver
// ----------------------------------------------------------------------------
package uart_pkg;

    // oversample ticks per bit and receive fifo slots
    localparam int OVERSAMPLE_RATIO = 16;
    localparam int RX_FIFO_DEPTH    = 16;

    // tick counter reaches the full ratio before wrapping
    localparam int TICK_W = $clog2(OVERSAMPLE_RATIO + 1);
    localparam int PTR_W  = $clog2(RX_FIFO_DEPTH);

    localparam logic [TICK_W-1:0] TICKS_FULL = TICK_W'(OVERSAMPLE_RATIO);
    localparam logic [TICK_W-1:0] TICKS_HALF = TICK_W'(OVERSAMPLE_RATIO / 2);
    localparam logic [PTR_W-1:0]  PTR_LAST   = PTR_W'(RX_FIFO_DEPTH - 1);

    // bit positions within a frame
    localparam logic [3:0] POS_START = 4'd0;
    localparam logic [3:0] POS_FIRST = 4'd1;
    localparam logic [3:0] POS_STOP  = 4'd9;
    localparam logic [3:0] POS_DONE  = 4'd10;

    // stream payload widths
    localparam int IN_W  = 16;
    localparam int OUT_W = 16;

    // received byte offered to the fifo
    typedef struct packed {
        logic       push;
        logic [7:0] data;
    } rx_push_t;

    // fifo status after the current tick
    typedef struct packed {
        logic read_valid;
        logic available;
        logic overrun;
    } fifo_status_t;

    // transmitter status after the current tick
    typedef struct packed {
        logic level;
        logic pending;
    } tx_status_t;

endpackage

### sv/uart_rx_fifo.sv
// ----------------------------------------------------------------------------
// uart_rx_fifo
// receive ring buffer in a synchronous memory, one slot kept empty
// ----------------------------------------------------------------------------
module uart_rx_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   tick,
    input  logic                   take_byte,
    input  uart_pkg::rx_push_t     push,
    output logic [7:0]             rd_data,
    output uart_pkg::fifo_status_t status
);
    import uart_pkg::*;

    logic [7:0]       mem [RX_FIFO_DEPTH];
    logic [7:0]       rd_data_reg;
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [PTR_W-1:0] wptr_inc;
    logic             pop;
    logic             wr_en;
    logic             full;

    // pop goes first so a push sees the freed slot
    always_comb
    begin
        pop       = tick && take_byte && (rptr_reg != wptr_reg);
        rptr_next = rptr_reg;
        if (pop)
        begin
            rptr_next = (rptr_reg == PTR_LAST) ? '0 : rptr_reg + 1'b1;
        end
        wptr_inc  = (wptr_reg == PTR_LAST) ? '0 : wptr_reg + 1'b1;
        full      = (wptr_inc == rptr_next);
        wr_en     = tick && push.push && !full;
        wptr_next = wr_en ? wptr_inc : wptr_reg;

        status.read_valid = pop;
        status.available  = (rptr_next != wptr_next);
        status.overrun    = tick && push.push && full;
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
        end
    end

    // storage, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wptr_reg] <= push.data;
        end
        if (pop)
        begin
            rd_data_reg <= mem[rptr_reg];
        end
    end

    assign rd_data = rd_data_reg;

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(wptr_reg) < RX_FIFO_DEPTH) && (int'(rptr_reg) < RX_FIFO_DEPTH))
        else $error("fifo pointer out of range");

    a_write_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (rptr_reg != wptr_reg))
        else $error("fifo empty after a write");

    a_overrun_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        status.overrun |=> $stable(wptr_reg))
        else $error("write pointer moved on overrun");

endmodule

### sv/uart_rx.sv
// ----------------------------------------------------------------------------
// uart_rx
// start detection, mid-bit sampling and byte assembly
// ----------------------------------------------------------------------------
module uart_rx (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tick,
    input  logic               level,
    output uart_pkg::rx_push_t push
);
    import uart_pkg::*;

    logic              busy_reg,  busy_next;
    logic [TICK_W-1:0] ticks_reg, ticks_next;
    logic [3:0]        pos_reg,   pos_next;
    logic [7:0]        shift_reg, shift_next;
    logic [TICK_W-1:0] ticks_inc;
    logic [2:0]        bit_idx;

    // framing
    always_comb
    begin
        busy_next  = busy_reg;
        ticks_next = ticks_reg;
        pos_next   = pos_reg;
        shift_next = shift_reg;
        push.push  = 1'b0;
        push.data  = shift_reg;
        ticks_inc  = ticks_reg + 1'b1;
        bit_idx    = 3'(pos_reg - POS_FIRST);

        if (!busy_reg)
        begin
            if (!level)
            begin
                busy_next  = 1'b1;
                ticks_next = '0;
                pos_next   = POS_START;
                shift_next = '0;
            end
        end
        else
        begin
            ticks_next = ticks_inc;
            if (ticks_inc == TICKS_HALF)
            begin
                if (pos_reg == POS_START)
                begin
                    if (level)
                    begin
                        busy_next = 1'b0;
                    end
                    else
                    begin
                        pos_next = POS_FIRST;
                    end
                end
                else if (pos_reg < POS_STOP)
                begin
                    shift_next[bit_idx] = level;
                    pos_next            = pos_reg + 1'b1;
                end
                else
                begin
                    busy_next = 1'b0;
                    push.push = level;
                end
            end
            else if (ticks_inc >= TICKS_FULL)
            begin
                ticks_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            ticks_reg <= '0;
            pos_reg   <= POS_START;
            shift_reg <= '0;
        end
        else if (tick)
        begin
            busy_reg  <= busy_next;
            ticks_reg <= ticks_next;
            pos_reg   <= pos_next;
            shift_reg <= shift_next;
        end
    end

endmodule

### sv/uart_tx.sv
// ----------------------------------------------------------------------------
// uart_tx
// holding register and frame serializer, each bit one full ratio of ticks
// ----------------------------------------------------------------------------
module uart_tx (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 tick,
    input  logic                 send_valid,
    input  logic [7:0]           send_byte,
    output uart_pkg::tx_status_t status
);
    import uart_pkg::*;

    logic              busy_reg,  busy_next;
    logic [TICK_W-1:0] ticks_reg, ticks_next;
    logic [3:0]        pos_reg,   pos_next;
    logic [7:0]        shift_reg, shift_next;
    logic [7:0]        hold_reg,  hold_next;
    logic              full_reg,  full_next;
    logic              level_reg, level_next;
    logic [TICK_W-1:0] ticks_inc;
    logic [3:0]        pos_inc;

    // serializer
    always_comb
    begin
        busy_next  = busy_reg;
        ticks_next = ticks_reg;
        pos_next   = pos_reg;
        shift_next = shift_reg;
        hold_next  = hold_reg;
        full_next  = full_reg;
        level_next = level_reg;
        ticks_inc  = ticks_reg + 1'b1;
        pos_inc    = pos_reg + 1'b1;

        if (send_valid)
        begin
            hold_next = send_byte;
            full_next = 1'b1;
        end

        if (busy_reg)
        begin
            ticks_next = ticks_inc;
            if (ticks_inc >= TICKS_FULL)
            begin
                ticks_next = '0;
                pos_next   = pos_inc;
                if (pos_inc < POS_STOP)
                begin
                    level_next = shift_reg[3'(pos_inc - POS_FIRST)];
                end
                else if (pos_inc == POS_STOP)
                begin
                    level_next = 1'b1;
                end
                else
                begin
                    busy_next = 1'b0;
                end
            end
        end

        // a byte loaded this tick may start this tick
        if (!busy_next && full_next)
        begin
            shift_next = hold_next;
            full_next  = 1'b0;
            busy_next  = 1'b1;
            ticks_next = '0;
            pos_next   = POS_START;
            level_next = 1'b0;
        end

        status.level   = level_next;
        status.pending = full_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            ticks_reg <= '0;
            pos_reg   <= POS_START;
            shift_reg <= '0;
            hold_reg  <= '0;
            full_reg  <= 1'b0;
            level_reg <= 1'b1;
        end
        else if (tick)
        begin
            busy_reg  <= busy_next;
            ticks_reg <= ticks_next;
            pos_reg   <= pos_next;
            shift_reg <= shift_next;
            hold_reg  <= hold_next;
            full_reg  <= full_next;
            level_reg <= level_next;
        end
    end

    a_idle_mark: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> level_reg)
        else $error("transmit line not at mark while idle");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pos_reg <= POS_STOP))
        else $error("transmit bit position past stop while busy");

endmodule

### sv/oversampled_uart_8n1_transceiver.sv
// ----------------------------------------------------------------------------
// oversampled_uart_8n1_transceiver
// oversampled 8n1 uart receiver with ring fifo and transmitter, one tick per transfer
// ----------------------------------------------------------------------------
// a tick's registered result shows on the master side in the cycle after its transfer
// throughput: one tick per cycle unless the master stalls; the output register frees
//   itself when taken; the fifo gives one write and one registered read per cycle
// reset: asynchronous, clears pointers, framers and the line to mark level;
//   the fifo memory is not cleared and is only read where it was written
module oversampled_uart_8n1_transceiver (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_data,       // line_invert
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // rx_line[0], send_valid[1], send_byte[9:2], take_byte[10], zero[15:11]
    input  logic [uart_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // tx_line[0], read_valid[1], read_byte[9:2], rx_available[10],
    // tx_pending[11], rx_overrun[12], zero[15:13]
    output logic [uart_pkg::OUT_W-1:0] m_axis_tdata
);
    import uart_pkg::*;

    logic         invert_reg;
    logic         tick;
    logic         rx_level;
    rx_push_t     rx_push;
    fifo_status_t fifo_status;
    tx_status_t   tx_status;
    logic [7:0]   fifo_rd_data;

    logic         out_valid_reg;
    logic         tx_line_reg;
    logic         read_valid_reg;
    logic         available_reg;
    logic         pending_reg;
    logic         overrun_reg;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invert_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            invert_reg <= cfg_data;
        end
    end

    // input transfer is one oversample tick
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign tick          = s_axis_tvalid && s_axis_tready;
    assign rx_level      = s_axis_tdata[0] ^ invert_reg;

    uart_rx u_rx (
        .clk   (clk),
        .rst_n (rst_n),
        .tick  (tick),
        .level (rx_level),
        .push  (rx_push)
    );

    uart_rx_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick),
        .take_byte (s_axis_tdata[10]),
        .push      (rx_push),
        .rd_data   (fifo_rd_data),
        .status    (fifo_status)
    );

    uart_tx u_tx (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (tick),
        .send_valid (s_axis_tdata[1]),
        .send_byte  (s_axis_tdata[9:2]),
        .status     (tx_status)
    );

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            out_valid_reg <= s_axis_tvalid;
        end
    end

    // output register payload, read byte comes from the fifo read register
    always_ff @(posedge clk)
    begin
        if (tick)
        begin
            tx_line_reg    <= tx_status.level ^ invert_reg;
            read_valid_reg <= fifo_status.read_valid;
            available_reg  <= fifo_status.available;
            pending_reg    <= tx_status.pending;
            overrun_reg    <= fifo_status.overrun;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, overrun_reg, pending_reg, available_reg,
                            (read_valid_reg ? fifo_rd_data : 8'h00),
                            read_valid_reg, tx_line_reg};

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        tick |=> m_axis_tvalid)
        else $error("accepted tick produced no result");

endmodule
